FILE: design/lpcp_pkg.sv
// ----------------------------------------------------------------------------
// lpcp_pkg
// shared types and constants of the lcd pixel command packer
// ----------------------------------------------------------------------------
package lpcp_pkg;

  // link command bytes
  localparam logic [7:0] CmdColumnSet   = 8'h2A;
  localparam logic [7:0] CmdRowSet      = 8'h2B;
  localparam logic [7:0] CmdMemoryWrite = 8'h2C;
  localparam logic [7:0] CmdContrast    = 8'h25;
  localparam logic [7:0] ContrastMask   = 8'h3F;

  // bit 8 of a link word
  localparam logic DataFlag = 1'b1;
  localparam logic CmdFlag  = 1'b0;

  localparam int unsigned WordW   = 9;
  localparam int unsigned MaxWords = 7;
  localparam int unsigned CntW    = 3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegPixelFormat = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd1;

  localparam logic [8:0] FrameWidthReset = 9'd132;

  typedef enum logic [1:0] {
    OpWindow   = 2'd0,
    OpPixel    = 2'd1,
    OpContrast = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    Fmt8  = 2'd0,
    Fmt12 = 2'd1,
    Fmt16 = 2'd2
  } fmt_e;

  // one queued job: the link words of one operation
  typedef struct packed {
    logic [MaxWords-1:0][WordW-1:0] words;
    logic [CntW-1:0]                count;
  } job_t;

endpackage

FILE: design/lcd_pixel_command_packer.sv
// ----------------------------------------------------------------------------
// lcd_pixel_command_packer
// turns display operations into 9-bit serial lcd link words
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o): one display operation per
//   transfer: set window, pixel or set contrast; op 3 is dropped
//   output channel (out_valid_o / out_stall_i): one link word per transfer,
//   bit 8 set for data, last_word_o marks the final word of an operation
//   config channel (cfg_valid_i / cfg_ready_o): pixel format and frame
//   width, always ready, write only while the packer is idle
// timing
//   the front builds all words of an operation in the cycle it is taken and
//   queues them; the first word then passes the queue and the output register
//   the back sends one word per cycle unless stalled: a window is 7 words, a
//   pixel 1, 2 or 3 (half of the 12 bpp pixels send none), a contrast op 2
//   the output word rate of one per cycle is the limit of the whole block
// reset
//   queue and output empty, no pixel held, 8 bpp, frame width 132
// stall
//   a stalled output word holds; the queue absorbs QueueDepth jobs before
//   in_stall_o rises
// ----------------------------------------------------------------------------
module lcd_pixel_command_packer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // operation input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [7:0]                    x_start_i,
  input  logic [7:0]                    y_start_i,
  input  logic [7:0]                    x_end_i,
  input  logic [7:0]                    y_end_i,
  input  logic [15:0]                   pixel_value_i,
  input  logic [7:0]                    contrast_value_i,
  // link word output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [8:0]                    lcd_word_o,
  output logic                          last_word_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [8:0]                    cfg_data_i
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           head_valid;
  lpcp_pkg::job_t push_job;
  lpcp_pkg::job_t head_job;

  // stall only when the job queue has no room
  assign in_stall_o  = queue_full;
  assign accept      = in_valid_i && !queue_full;
  assign cfg_ready_o = 1'b1;

  // front: classify the operation and build its words
  lpcp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .op_i             (op_i),
    .x_start_i        (x_start_i),
    .y_start_i        (y_start_i),
    .x_end_i          (x_end_i),
    .y_end_i          (y_end_i),
    .pixel_value_i    (pixel_value_i),
    .contrast_value_i (contrast_value_i),
    .cfg_write_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push_o           (push),
    .job_o            (push_job)
  );

  // job queue decouples front and back
  lpcp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .full_o      (queue_full),
    .valid_o     (head_valid),
    .head_o      (head_job)
  );

  // back: serialize words into the output register
  lpcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .lcd_word_o   (lcd_word_o),
    .last_word_o  (last_word_o)
  );

endmodule

FILE: design/lpcp_front.sv
// ----------------------------------------------------------------------------
// lpcp_front
// accepts operations, keeps config and the held 12 bpp pixel, builds word jobs
// ----------------------------------------------------------------------------
module lpcp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    op_i,
  input  logic [7:0]                    x_start_i,
  input  logic [7:0]                    y_start_i,
  input  logic [7:0]                    x_end_i,
  input  logic [7:0]                    y_end_i,
  input  logic [15:0]                   pixel_value_i,
  input  logic [7:0]                    contrast_value_i,
  input  logic                          cfg_write_i,
  input  logic [lpcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [8:0]                    cfg_data_i,
  output logic                          push_o,
  output lpcp_pkg::job_t                job_o
);

  logic [1:0]  pixel_format_q;
  logic [8:0]  frame_width_q;
  logic [11:0] held_pixel_q, held_pixel_d;
  logic        have_held_q, have_held_d;

  logic        widen;
  logic        fits;
  logic [7:0]  xs_adj;
  logic [7:0]  xe_adj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= 2'd0;
      frame_width_q  <= lpcp_pkg::FrameWidthReset;
      held_pixel_q   <= 12'd0;
      have_held_q    <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        case (cfg_index_i)
          lpcp_pkg::RegPixelFormat: pixel_format_q <= cfg_data_i[1:0];
          lpcp_pkg::RegFrameWidth:  frame_width_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        held_pixel_q <= held_pixel_d;
        have_held_q  <= have_held_d;
      end
    end
  end

  // 12 bpp edge rule on the column range
  always_comb begin
    widen  = (lpcp_pkg::fmt_e'(pixel_format_q) == lpcp_pkg::Fmt12) && !x_end_i[0];
    fits   = (frame_width_q != 9'd0) && ({1'b0, x_end_i} < (frame_width_q - 9'd1));
    xs_adj = x_start_i;
    xe_adj = x_end_i;
    if (widen) begin
      if (fits) begin
        xe_adj = x_end_i + 8'd1;
      end else begin
        xs_adj = x_start_i - 8'd1;
      end
    end
  end

  always_comb begin
    job_o        = '0;
    held_pixel_d = held_pixel_q;
    have_held_d  = have_held_q;
    case (lpcp_pkg::op_e'(op_i))
      lpcp_pkg::OpWindow: begin
        job_o.words[0] = {lpcp_pkg::CmdFlag, lpcp_pkg::CmdColumnSet};
        job_o.words[1] = {lpcp_pkg::DataFlag, xs_adj + 8'd1};
        job_o.words[2] = {lpcp_pkg::DataFlag, xe_adj + 8'd1};
        job_o.words[3] = {lpcp_pkg::CmdFlag, lpcp_pkg::CmdRowSet};
        job_o.words[4] = {lpcp_pkg::DataFlag, y_start_i + 8'd1};
        job_o.words[5] = {lpcp_pkg::DataFlag, y_end_i + 8'd1};
        job_o.words[6] = {lpcp_pkg::CmdFlag, lpcp_pkg::CmdMemoryWrite};
        job_o.count    = 3'd7;
        have_held_d    = 1'b0;
      end
      lpcp_pkg::OpPixel: begin
        case (lpcp_pkg::fmt_e'(pixel_format_q))
          lpcp_pkg::Fmt16: begin
            job_o.words[0] = {lpcp_pkg::DataFlag, pixel_value_i[15:8]};
            job_o.words[1] = {lpcp_pkg::DataFlag, pixel_value_i[7:0]};
            job_o.count    = 3'd2;
          end
          lpcp_pkg::Fmt12: begin
            if (!have_held_q) begin
              held_pixel_d = pixel_value_i[11:0];
              have_held_d  = 1'b1;
            end else begin
              job_o.words[0] = {lpcp_pkg::DataFlag, held_pixel_q[11:4]};
              job_o.words[1] = {lpcp_pkg::DataFlag, held_pixel_q[3:0], pixel_value_i[11:8]};
              job_o.words[2] = {lpcp_pkg::DataFlag, pixel_value_i[7:0]};
              job_o.count    = 3'd3;
              have_held_d    = 1'b0;
            end
          end
          default: begin
            job_o.words[0] = {lpcp_pkg::DataFlag, pixel_value_i[7:0]};
            job_o.count    = 3'd1;
          end
        endcase
      end
      lpcp_pkg::OpContrast: begin
        job_o.words[0] = {lpcp_pkg::CmdFlag, lpcp_pkg::CmdContrast};
        job_o.words[1] = {lpcp_pkg::DataFlag, contrast_value_i & lpcp_pkg::ContrastMask};
        job_o.count    = 3'd2;
      end
      default: ;
    endcase
  end

  // jobs with no words never enter the queue
  assign push_o = accept_i && (job_o.count != '0);

endmodule

FILE: design/lpcp_fifo.sv
// ----------------------------------------------------------------------------
// lpcp_fifo
// short register queue of word jobs between front and back
// ----------------------------------------------------------------------------
module lpcp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpcp_pkg::job_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output lpcp_pkg::job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  lpcp_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/lpcp_back.sv
// ----------------------------------------------------------------------------
// lpcp_back
// walks the head job word by word into the output register
// ----------------------------------------------------------------------------
module lpcp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  lpcp_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [8:0]     lcd_word_o,
  output logic           last_word_o
);

  logic [lpcp_pkg::CntW-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  logic [8:0]                lcd_word_q;
  logic                      last_word_q;
  logic                      load;
  logic                      is_last;

  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == (head_i.count - 1'b1));
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lcd_word_q  <= head_i.words[idx_q];
      last_word_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign lcd_word_o  = lcd_word_q;
  assign last_word_o = last_word_q;

endmodule
